// ===== hdl/irfe_pkg.sv =====
package irfe_pkg;

  localparam int unsigned TIMER_BITS_DEF = 24;
  localparam int unsigned CFG_DATA_W     = 24;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned DUR_W          = 24;
  localparam int unsigned EMIT_W         = 4;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_ID            = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_HALF_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_TICKS         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_TICKS          = 3'd4;

  localparam logic [CNT_W-1:0] RST_PREAMBLE_COUNT      = 8'd5;
  localparam logic [CNT_W-1:0] RST_BOARD_ID            = 8'd0;
  localparam logic [DUR_W-1:0] RST_PREAMBLE_HALF_TICKS = 24'd150000;
  localparam logic [DUR_W-1:0] RST_SHORT_TICKS         = 24'd70000;
  localparam logic [DUR_W-1:0] RST_LONG_TICKS          = 24'd280000;

  localparam logic [EMIT_W-1:0] EMIT_ALL     = 4'hF;
  localparam logic [EMIT_W-1:0] EMIT_NONE    = 4'h0;
  localparam logic [EMIT_W-1:0] EMIT_ONES_B0 = 4'hC;  // emitters 2,3 have MSB set
  localparam logic [EMIT_W-1:0] EMIT_ONES_B1 = 4'hA;  // emitters 1,3 have LSB set

  typedef enum logic [5:0] {
    SEG_PRE_HI = 6'b000001,
    SEG_PRE_LO = 6'b000010,
    SEG_ID_HI  = 6'b000100,
    SEG_ID_LO  = 6'b001000,
    SEG_EM_A   = 6'b010000,
    SEG_EM_B   = 6'b100000
  } seg_e;

  typedef struct packed {
    logic [CNT_W-1:0] preamble_count;
    logic [CNT_W-1:0] board_id;
    logic [DUR_W-1:0] preamble_half_ticks;
    logic [DUR_W-1:0] short_ticks;
    logic [DUR_W-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    seg_e             seg;
    logic [CNT_W-1:0] done;
    logic             bit_idx;
  } seq_state_t;

endpackage

// ===== hdl/irfe_seq.sv =====
module irfe_seq #(
  parameter int unsigned TIMER_BITS = irfe_pkg::TIMER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  irfe_pkg::cfg_t        cfg_i,
  input  logic                  step_i,
  input  logic                  advance_i,
  output irfe_pkg::seq_state_t  state_o,
  output logic [TIMER_BITS-1:0] tick_o
);
  import irfe_pkg::*;

  localparam int unsigned CW = ((TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W) + 1;

  seg_e                  seg_q, seg_d;
  logic [TIMER_BITS-1:0] tick_q, tick_d;
  logic [CNT_W-1:0]      done_q, done_d;
  logic                  bit_q, bit_d;

  logic             id_bit;
  logic [DUR_W-1:0] seg_len;
  logic [CW-1:0]    tick_inc;
  logic             seg_end;
  logic [CNT_W-1:0] done_inc;
  seg_e             frame_seg;

  // IDs above three are sent as zero
  assign id_bit = (cfg_i.board_id[CNT_W-1:2] == '0) ? cfg_i.board_id[bit_q] : 1'b0;

  always_comb begin
    case (seg_q)
      SEG_PRE_HI, SEG_PRE_LO: seg_len = cfg_i.preamble_half_ticks;
      SEG_ID_HI:              seg_len = id_bit ? cfg_i.long_ticks : cfg_i.short_ticks;
      SEG_ID_LO:              seg_len = id_bit ? cfg_i.short_ticks : cfg_i.long_ticks;
      SEG_EM_A:               seg_len = cfg_i.short_ticks;
      SEG_EM_B:               seg_len = cfg_i.long_ticks;
      default:                seg_len = DUR_W'(1);
    endcase
  end

  // timer saturates at all ones
  assign tick_inc  = CW'(tick_q) + CW'(1);
  assign seg_end   = (tick_inc >= CW'(seg_len)) || (&tick_q);
  assign done_inc  = done_q + CNT_W'(1);
  assign frame_seg = (cfg_i.preamble_count != '0) ? SEG_PRE_HI : SEG_ID_HI;

  always_comb begin
    seg_d  = seg_q;
    tick_d = tick_q;
    done_d = done_q;
    bit_d  = bit_q;
    if (step_i && advance_i) begin
      if (!seg_end) begin
        tick_d = tick_inc[TIMER_BITS-1:0];
      end else begin
        tick_d = '0;
        case (seg_q)
          SEG_PRE_HI: seg_d = SEG_PRE_LO;
          SEG_PRE_LO: begin
            // wrap of the count also ends the preamble
            if (done_inc >= cfg_i.preamble_count || done_inc == '0) begin
              done_d = '0;
              bit_d  = 1'b0;
              seg_d  = SEG_ID_HI;
            end else begin
              done_d = done_inc;
              seg_d  = SEG_PRE_HI;
            end
          end
          SEG_ID_HI: seg_d = SEG_ID_LO;
          SEG_ID_LO: begin
            if (!bit_q) begin
              bit_d = 1'b1;
              seg_d = SEG_ID_HI;
            end else begin
              bit_d = 1'b0;
              seg_d = SEG_EM_A;
            end
          end
          SEG_EM_A: seg_d = SEG_EM_B;
          SEG_EM_B: begin
            if (!bit_q) begin
              bit_d = 1'b1;
              seg_d = SEG_EM_A;
            end else begin
              seg_d  = frame_seg;
              done_d = '0;
              bit_d  = 1'b0;
            end
          end
          default: begin
            seg_d  = frame_seg;
            done_d = '0;
            bit_d  = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q  <= SEG_PRE_HI;
      tick_q <= '0;
      done_q <= '0;
      bit_q  <= 1'b0;
    end else begin
      seg_q  <= seg_d;
      tick_q <= tick_d;
      done_q <= done_d;
      bit_q  <= bit_d;
    end
  end

  assign state_o.seg     = seg_q;
  assign state_o.done    = done_q;
  assign state_o.bit_idx = bit_q;
  assign tick_o          = tick_q;

`ifndef SYNTHESIS
  // preamble count only lives inside the preamble
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_q != SEG_PRE_HI && seg_q != SEG_PRE_LO) |-> done_q == '0)
    else $error("preamble count left set outside preamble");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_q == SEG_PRE_HI || seg_q == SEG_PRE_LO) |-> !bit_q)
    else $error("bit index set during preamble");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(step_i && advance_i) |=> $stable(seg_q) && $stable(tick_q) && $stable(done_q)
      && $stable(bit_q))
    else $error("state moved without a tick");
`endif

endmodule

// ===== hdl/irfe_env.sv =====
module irfe_env #(
  parameter int unsigned TIMER_BITS = irfe_pkg::TIMER_BITS_DEF
) (
  input  irfe_pkg::cfg_t                    cfg_i,
  input  irfe_pkg::seq_state_t              state_i,
  input  logic [TIMER_BITS-1:0]             tick_i,
  output logic [irfe_pkg::EMIT_W-1:0]       emitter_on_o,
  output logic                              frame_start_o
);
  import irfe_pkg::*;

  localparam int unsigned CW = ((TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W) + 2;

  logic [EMIT_W-1:0] ones;
  logic              t_lt_long;
  logic              st_lt_long;

  assign ones       = state_i.bit_idx ? EMIT_ONES_B1 : EMIT_ONES_B0;
  assign t_lt_long  = CW'(tick_i) < CW'(cfg_i.long_ticks);
  // a one-bit emitter stays high for long_ticks across both parts
  assign st_lt_long = (CW'(cfg_i.short_ticks) + CW'(tick_i)) < CW'(cfg_i.long_ticks);

  always_comb begin
    case (state_i.seg)
      SEG_PRE_HI, SEG_ID_HI: emitter_on_o = EMIT_ALL;
      SEG_PRE_LO, SEG_ID_LO: emitter_on_o = EMIT_NONE;
      SEG_EM_A:              emitter_on_o = t_lt_long ? EMIT_ALL : (EMIT_ALL & ~ones);
      SEG_EM_B:              emitter_on_o = st_lt_long ? ones : EMIT_NONE;
      default:               emitter_on_o = EMIT_NONE;
    endcase
  end

  assign frame_start_o = (tick_i == '0) && (state_i.done == '0) && !state_i.bit_idx &&
                         ((state_i.seg == SEG_PRE_HI) ||
                          (state_i.seg == SEG_ID_HI && cfg_i.preamble_count == '0));

endmodule

// ===== hdl/ir_frame_pulse_width_encoder_unit.sv =====
// channel | dir | handshake               | payload
// --------+-----+-------------------------+------------------------------
// in      | in  | in_valid_i / in_ready_o | advance_i
// out     | out | out_valid_o/ out_ready_i| emitter_on_o, frame_start_o
// cfg     | in  | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One beat per cycle in while in_ready_o is high, one result beat per input beat,
// registered in the cycle after acceptance. The result is decoded from the tick state at acceptance and held in the
// output register; the tick state updates on the same edge.
// in_ready_o drops only while a result sits unclaimed and out_ready_i is low.
// Reset loads the register defaults and the start of a preamble.
module ir_frame_pulse_width_encoder_unit #(
  parameter int unsigned TIMER_BITS = irfe_pkg::TIMER_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               advance_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [irfe_pkg::EMIT_W-1:0]        emitter_on_o,
  output logic                               frame_start_o,
  input  logic                               cfg_we_i,
  input  logic [irfe_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [irfe_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import irfe_pkg::*;

  cfg_t                  cfg_q;
  seq_state_t            state;
  logic [TIMER_BITS-1:0] tick;
  logic                  accept;
  logic [EMIT_W-1:0]     emit_d, emit_q;
  logic                  fs_d, fs_q;
  logic                  out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preamble_count      <= RST_PREAMBLE_COUNT;
      cfg_q.board_id            <= RST_BOARD_ID;
      cfg_q.preamble_half_ticks <= RST_PREAMBLE_HALF_TICKS;
      cfg_q.short_ticks         <= RST_SHORT_TICKS;
      cfg_q.long_ticks          <= RST_LONG_TICKS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PREAMBLE_COUNT:      cfg_q.preamble_count      <= cfg_data_i[CNT_W-1:0];
        REG_BOARD_ID:            cfg_q.board_id            <= cfg_data_i[CNT_W-1:0];
        REG_PREAMBLE_HALF_TICKS: cfg_q.preamble_half_ticks <= cfg_data_i[DUR_W-1:0];
        REG_SHORT_TICKS:         cfg_q.short_ticks         <= cfg_data_i[DUR_W-1:0];
        REG_LONG_TICKS:          cfg_q.long_ticks          <= cfg_data_i[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  irfe_seq #(
    .TIMER_BITS(TIMER_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .step_i    (accept),
    .advance_i (advance_i),
    .state_o   (state),
    .tick_o    (tick)
  );

  irfe_env #(
    .TIMER_BITS(TIMER_BITS)
  ) u_env (
    .cfg_i         (cfg_q),
    .state_i       (state),
    .tick_i        (tick),
    .emitter_on_o  (emit_d),
    .frame_start_o (fs_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      emit_q <= emit_d;
      fs_q   <= fs_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign emitter_on_o  = emit_q;
  assign frame_start_o = fs_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted beat produced no result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output register");

  // a frame always opens on an all-high segment
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_start_o) |-> emitter_on_o == EMIT_ALL)
    else $error("frame start without all emitters on");
`endif

endmodule

// ===== tb/tb_ir_frame_pulse_width_encoder_unit.sv =====
module tb_ir_frame_pulse_width_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import irfe_pkg::*;

  typedef struct packed {
    logic [EMIT_W-1:0] emit;
    logic              fs;
  } envelope_t;

  // Tracks the frame sequencer and holds the envelopes still owed by the block.
  class pulse_frame_scoreboard;
    logic [CNT_W-1:0]          pre_count;
    logic [CNT_W-1:0]          board_id;
    logic [DUR_W-1:0]          half_t;
    logic [DUR_W-1:0]          short_t;
    logic [DUR_W-1:0]          long_t;
    seg_e                      seg;
    logic [TIMER_BITS_DEF-1:0] ticks;
    logic [CNT_W-1:0]          done;
    logic                      bit_idx;
    envelope_t                 pending_q[$];
    int                        mismatches;
    int                        checked;
    int                        frames;

    function new();
      pre_count  = RST_PREAMBLE_COUNT;
      board_id   = RST_BOARD_ID;
      half_t     = RST_PREAMBLE_HALF_TICKS;
      short_t    = RST_SHORT_TICKS;
      long_t     = RST_LONG_TICKS;
      seg        = SEG_PRE_HI;
      ticks      = '0;
      done       = '0;
      bit_idx    = 1'b0;
      mismatches = 0;
      checked    = 0;
      frames     = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_PREAMBLE_COUNT:      pre_count = data[CNT_W-1:0];
        REG_BOARD_ID:            board_id  = data[CNT_W-1:0];
        REG_PREAMBLE_HALF_TICKS: half_t    = data[DUR_W-1:0];
        REG_SHORT_TICKS:         short_t   = data[DUR_W-1:0];
        REG_LONG_TICKS:          long_t    = data[DUR_W-1:0];
        default: ;
      endcase
    endfunction

    function logic id_bit();
      logic [CNT_W-1:0] id;
      id = (board_id > 3) ? '0 : board_id;
      return id[bit_idx];
    endfunction

    function logic [DUR_W-1:0] seg_ticks();
      case (seg)
        SEG_PRE_HI, SEG_PRE_LO: return half_t;
        SEG_ID_HI:              return id_bit() ? long_t : short_t;
        SEG_ID_LO:              return id_bit() ? short_t : long_t;
        SEG_EM_A:               return short_t;
        SEG_EM_B:               return long_t;
        default:                return DUR_W'(1);
      endcase
    endfunction

    function logic [EMIT_W-1:0] emitters_now();
      logic [EMIT_W-1:0] ones;
      ones = bit_idx ? EMIT_ONES_B1 : EMIT_ONES_B0;
      case (seg)
        SEG_PRE_HI, SEG_ID_HI: return EMIT_ALL;
        SEG_EM_A: return (32'(ticks) < 32'(long_t)) ? EMIT_ALL : (EMIT_ALL & ~ones);
        SEG_EM_B: return (32'(short_t) + 32'(ticks) < 32'(long_t)) ? ones : EMIT_NONE;
        default:  return EMIT_NONE;
      endcase
    endfunction

    function void new_frame();
      seg     = (pre_count > 0) ? SEG_PRE_HI : SEG_ID_HI;
      done    = '0;
      bit_idx = 1'b0;
    endfunction

    function void next_seg();
      ticks = '0;
      case (seg)
        SEG_PRE_HI: seg = SEG_PRE_LO;
        SEG_PRE_LO: begin
          done = done + 1'b1;
          // wrap of the period counter also ends the preamble
          if (done >= pre_count || done == 0) begin
            done    = '0;
            bit_idx = 1'b0;
            seg     = SEG_ID_HI;
          end else begin
            seg = SEG_PRE_HI;
          end
        end
        SEG_ID_HI: seg = SEG_ID_LO;
        SEG_ID_LO: begin
          if (!bit_idx) begin
            bit_idx = 1'b1;
            seg     = SEG_ID_HI;
          end else begin
            bit_idx = 1'b0;
            seg     = SEG_EM_A;
          end
        end
        SEG_EM_A: seg = SEG_EM_B;
        SEG_EM_B: begin
          if (!bit_idx) begin
            bit_idx = 1'b1;
            seg     = SEG_EM_A;
          end else begin
            new_frame();
          end
        end
        default: new_frame();
      endcase
    endfunction

    function void note_input(logic adv);
      envelope_t e;
      e.emit = emitters_now();
      e.fs   = (ticks == 0) && (done == 0) && !bit_idx &&
               (seg == SEG_PRE_HI || (seg == SEG_ID_HI && pre_count == 0));
      pending_q.push_back(e);
      if (adv) begin
        if (32'(ticks) + 32'd1 >= 32'(seg_ticks()) || ticks == '1) next_seg();
        else ticks = ticks + 1'b1;
      end
    endfunction

    function void check_result(logic [EMIT_W-1:0] emit, logic fs);
      envelope_t e;
      if (pending_q.size() == 0) begin
        $error("result beat with no envelope pending: emitter_on %h frame_start %b", emit, fs);
        mismatches++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (e.fs) frames++;
      if (emit !== e.emit) begin
        $error("emitter_on mismatch: expected %h, actual %h", e.emit, emit);
        mismatches++;
      end
      if (fs !== e.fs) begin
        $error("frame_start mismatch: expected %b, actual %b", e.fs, fs);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  advance_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [EMIT_W-1:0]     emitter_on_o;
  logic                  frame_start_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pulse_frame_scoreboard sb = new();
  int settings_cnt = 0;
  int stall_cycles = 0;

  ir_frame_pulse_width_encoder_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .advance_i     (advance_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .emitter_on_o  (emitter_on_o),
    .frame_start_o (frame_start_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("FAILURE");
    $finish;
  end

  // beats seen on the clock edge, before this edge's drive takes effect
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(emitter_on_o, frame_start_o);
      if (in_valid_i && in_ready_o) sb.note_input(advance_i);
      if (in_valid_i && !in_ready_o) stall_cycles++;
    end
  end

  // receiver: stretches of steady, random and mostly-ready, plus a long hold-off
  initial begin
    int stretch;
    int mode;
    int len;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    stretch = 0;
    forever begin
      stretch++;
      if (stretch % 9 == 4) begin
        mode = 3;
        len  = 150;
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 60);
      end
      repeat (len) begin
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 4) != 0);
          default: out_ready_i <= 1'b0;
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(input logic adv);
    in_valid_i <= 1'b1;
    advance_i  <= adv;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_offering();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // write enable stays up across back-to-back writes; end_writes drops it
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
  endtask

  task automatic end_writes();
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_cnt++;
  endtask

  task automatic send_run(input int n, input int zero_pct);
    int left;
    int burst;
    int gap;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      while (burst > 0 && left > 0) begin
        send_beat($urandom_range(0, 99) >= zero_pct);
        burst--;
        left--;
      end
      gap = $urandom_range(0, 8);
      if (left > 0 && gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    stop_offering();
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return DUR_W'($urandom);
    if (r < 4) return DUR_W'($urandom_range(0, 40));
    return DUR_W'($urandom_range(0, 6));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CNT_W-1:0] v);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    d[CNT_W-1:0] = v;
    return d;
  endfunction

  // rewrites a random subset, so changes often land mid-frame
  task automatic random_settings();
    int r;
    logic [CNT_W-1:0] v;
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 9);
      v = (r < 7) ? CNT_W'($urandom_range(0, 3)) :
          (r == 7) ? '1 : CNT_W'($urandom_range(0, 255));
      write_reg(REG_PREAMBLE_COUNT, with_junk(v));
    end
    if ($urandom_range(0, 9) < 7) begin
      v = ($urandom_range(0, 3) != 0) ? CNT_W'($urandom_range(0, 3))
                                      : CNT_W'($urandom_range(4, 255));
      write_reg(REG_BOARD_ID, with_junk(v));
    end
    if ($urandom_range(0, 9) < 7) write_reg(REG_PREAMBLE_HALF_TICKS, pick_duration());
    if ($urandom_range(0, 9) < 7) write_reg(REG_SHORT_TICKS, pick_duration());
    if ($urandom_range(0, 9) < 7) write_reg(REG_LONG_TICKS, pick_duration());
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_IDX_W'(REG_LONG_TICKS + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
    end_writes();
  endtask

  initial begin
    int p;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    advance_i   <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults straight out of reset
    send_beat(1'b1);
    send_beat(1'b0);
    send_beat(1'b1);
    stop_offering();
    drain();

    // no preamble, ID 3, zero short duration, written while still in a long preamble half
    write_reg(REG_PREAMBLE_COUNT, '0);
    write_reg(REG_BOARD_ID, CFG_DATA_W'(3));
    write_reg(REG_PREAMBLE_HALF_TICKS, '1);
    write_reg(REG_SHORT_TICKS, '0);
    write_reg(REG_LONG_TICKS, CFG_DATA_W'(1));
    end_writes();
    for (int i = 0; i < 10; i++) send_beat(i != 4);
    stop_offering();
    drain();

    // everything at its maximum; ID above three
    write_reg(REG_PREAMBLE_COUNT, '1);
    write_reg(REG_BOARD_ID, '1);
    write_reg(REG_SHORT_TICKS, '1);
    write_reg(REG_LONG_TICKS, '1);
    end_writes();
    repeat (3) send_beat(1'b1);
    stop_offering();
    drain();

    // long shorter than short, then preamble count dropped to zero mid-preamble
    write_reg(REG_PREAMBLE_COUNT, CFG_DATA_W'(3));
    write_reg(REG_BOARD_ID, CFG_DATA_W'(2));
    write_reg(REG_PREAMBLE_HALF_TICKS, CFG_DATA_W'(1));
    write_reg(REG_SHORT_TICKS, CFG_DATA_W'(2));
    write_reg(REG_LONG_TICKS, CFG_DATA_W'(1));
    end_writes();
    repeat (3) send_beat(1'b1);
    stop_offering();
    drain();
    write_reg(REG_PREAMBLE_COUNT, '0);
    write_reg(CFG_IDX_W'(REG_LONG_TICKS + 1), '1);
    end_writes();
    repeat (6) send_beat(1'b1);
    stop_offering();
    drain();

    for (p = 0; p < 11; p++) begin
      random_settings();
      send_run($urandom_range(90, 120), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40));
      drain();
    end

    repeat (4) @(posedge clk_i);
    if (sb.pending_q.size() != 0) begin
      $error("%0d envelopes never arrived", sb.pending_q.size());
      sb.mismatches++;
    end
    $display("Checked %0d envelope beats under %0d register settings, %0d frame starts.",
             sb.checked, settings_cnt, sb.frames);
    $display("Input held off by the block for %0d cycles.", stall_cycles);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
